### hw/rtl/block_mix_key_hash_assert.svh
// ----------------------------------------------------------------------------
// block_mix_key_hash assertion macros
// Clocked assertion wrappers for the key hash block. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MIX_KEY_HASH_ASSERT_SVH
`define BLOCK_MIX_KEY_HASH_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define BMKH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("block_mix_key_hash: check failed");
// Checked at every rising edge, reset included.
`define BMKH_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("block_mix_key_hash: check failed");
`else
`define BMKH_ASSERT(lbl, prop)
`define BMKH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hw/rtl/bmkh_pkg.sv
// ----------------------------------------------------------------------------
// bmkh_pkg
// Shared types, constants and the mixing step of the lookup2 key hash.
// ----------------------------------------------------------------------------
package bmkh_pkg;

	// Input actions carried in tuser.
	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_ADD_FIN = 2'd1;
	localparam logic [1:0] ACT_FIN     = 2'd2;

	localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
	localparam logic [31:0] INIT_RESET   = 32'd1000;

	// The front holds bytes 0..10; byte 11 completes a block on arrival.
	localparam int          HELD_BYTES = 11;
	localparam logic [3:0]  FILL_LAST  = 4'd11;

	localparam logic [3:0]  MIX_LAST = 4'd8;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int         ADDR_W       = 3;
	localparam logic [0:0] REG_INIT_IDX = 1'b0;

	// One unit of work for the mixing back end.
	typedef struct packed {
		logic        new_key;
		logic        do_block;
		logic        do_finish;
		logic [31:0] seed;
		logic [31:0] add_a;
		logic [31:0] add_b;
		logic [31:0] add_c;
		logic [31:0] key_len;
	} job_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MIX  = 2'd1,
		BK_TAIL = 2'd2,
		BK_EMIT = 2'd3
	} back_state_t;

	// One line of the mix: x -= y; x -= z; x ^= shifted z.
	function automatic logic [31:0] mix_line(input logic [3:0] step,
	                                         input logic [31:0] x,
	                                         input logic [31:0] y,
	                                         input logic [31:0] z);
		logic [31:0] d;
		logic [31:0] s;
		d = x - y - z;
		case (step)
			4'd0: s = z >> 13;
			4'd1: s = z << 8;
			4'd2: s = z >> 13;
			4'd3: s = z >> 12;
			4'd4: s = z << 16;
			4'd5: s = z >> 5;
			4'd6: s = z >> 3;
			4'd7: s = z << 10;
			default: s = z >> 15;
		endcase
		return d ^ s;
	endfunction

endpackage

### hw/rtl/block_mix_key_hash.sv
// ----------------------------------------------------------------------------
// block_mix_key_hash
// Lookup2 hash of a byte key streamed one byte per transfer.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser: action, tdata: data_byte
//   m_axis    out  m_axis_tvalid/tready       tdata: hash_value
//   apb       in   psel/penable/pwrite/pready pwdata/prdata: init_value @ 0x0
//
// Key bytes are taken one per cycle. A full 12-byte block costs the mixer a
// load and nine mix lines; a finish costs a load, the length add and nine
// mix lines before the hash is handed off, and a byte that completes a block
// puts nine more mix lines in front of that.
// A four-job queue lets the front keep taking bytes while the mixer works;
// s_axis_tready drops only while that queue is full.
// Reset clears all control state and sets init_value to 1000.
// ----------------------------------------------------------------------------
module block_mix_key_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	// tdata: data_byte[7:0]
	input  logic [7:0]                  s_axis_tdata,
	// tuser: action[1:0]
	input  logic [1:0]                  s_axis_tuser,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// tdata: hash_value[31:0]
	output logic [31:0]                 m_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmkh_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bmkh_pkg::*;

`include "block_mix_key_hash_assert.svh"

	logic        [31:0] init_q;
	logic               cfg_write;
	job_t               front_job;
	job_t               q_job;
	logic               push;
	logic               pop;
	q_status_t          q_status;
	logic               res_valid;
	logic        [31:0] res_hash;
	logic               res_ready;
	logic               out_valid_q;
	logic        [31:0] out_hash_q;
	logic [Q_CNT_W-1:0] count_inc;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
	                   && (paddr[ADDR_W-1:2] == REG_INIT_IDX);
	assign prdata    = (paddr[ADDR_W-1:2] == REG_INIT_IDX) ? init_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RESET;
		end else if (cfg_write) begin
			init_q <= pwdata;
		end
	end

	bmkh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.data_byte  (s_axis_tdata),
		.init_value (init_q),
		.job        (front_job),
		.job_push   (push),
		.q_status   (q_status)
	);

	bmkh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_job),
		.pop    (pop),
		.dout   (q_job),
		.status (q_status)
	);

	bmkh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_job     (q_job),
		.q_status  (q_status),
		.q_pop     (pop),
		.res_valid (res_valid),
		.res_hash  (res_hash),
		.res_ready (res_ready)
	);

	// Output register: the mixer hands off a hash whenever the slot is free
	// or being emptied in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_hash_q <= res_hash;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_hash_q;

	assign count_inc = q_status.count + 1'b1;

	`BMKH_ASSERT(a_queue_bound, q_status.count <= Q_CNT_W'(Q_DEPTH))
	`BMKH_ASSERT(a_queue_track, push && !pop && !q_status.full |=> q_status.count == $past(count_inc))
	`BMKH_ASSERT(a_out_from_back, $rose(m_axis_tvalid) |-> $past(res_valid))
	`BMKH_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_axis_tvalid && q_status.empty)

endmodule

### hw/rtl/bmkh_front.sv
// ----------------------------------------------------------------------------
// bmkh_front
// Collects key bytes, tracks block fill and key length, and hands block and
// finish jobs to the queue.
// ----------------------------------------------------------------------------
module bmkh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [7:0]          data_byte,
	input  logic [31:0]         init_value,
	output bmkh_pkg::job_t      job,
	output logic                job_push,
	input  bmkh_pkg::q_status_t q_status
);
	import bmkh_pkg::*;

	logic [7:0]  bytes_q [HELD_BYTES];
	logic [3:0]  fill_q;
	logic [31:0] len_q;
	logic        open_q;
	logic        newkey_q;
	logic [31:0] seed_q;

	logic        accept;
	logic        is_add;
	logic        is_fin;
	logic        blk_done;
	logic [3:0]  cnt;
	logic [7:0]  m [HELD_BYTES];
	logic [31:0] len_next;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_add = 1'b0;
		is_fin = 1'b0;
		case (action)
			ACT_ADD: begin
				is_add = 1'b1;
			end
			ACT_ADD_FIN: begin
				is_add = 1'b1;
				is_fin = 1'b1;
			end
			ACT_FIN: begin
				is_fin = 1'b1;
			end
			default: begin
				is_add = 1'b0;
				is_fin = 1'b0;
			end
		endcase
	end

	assign blk_done = is_add && (fill_q == FILL_LAST);
	assign cnt      = fill_q + 4'(is_add);
	assign len_next = len_q + 32'(is_add);

	// Bytes as they stand after this transfer, masked to the valid tail.
	always_comb begin
		for (int i = 0; i < HELD_BYTES; i++) begin
			logic [7:0] eff;
			eff  = (is_add && fill_q == 4'(i)) ? data_byte : bytes_q[i];
			m[i] = (blk_done || 4'(i) < cnt) ? eff : 8'h00;
		end
	end

	always_comb begin
		job.new_key   = newkey_q;
		job.do_block  = blk_done;
		job.do_finish = is_fin;
		job.seed      = open_q ? seed_q : init_value;
		job.add_a     = {m[3], m[2], m[1], m[0]};
		job.add_b     = {m[7], m[6], m[5], m[4]};
		// In the tail the lowest byte of word c is left for the length.
		job.add_c     = blk_done ? {data_byte, m[10], m[9], m[8]}
		                         : {m[10], m[9], m[8], 8'h00};
		job.key_len   = len_next;
	end

	assign job_push = accept && (blk_done || is_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			len_q    <= '0;
			open_q   <= 1'b0;
			newkey_q <= 1'b1;
		end else if (accept) begin
			if (is_fin) begin
				fill_q   <= '0;
				len_q    <= '0;
				open_q   <= 1'b0;
				newkey_q <= 1'b1;
			end else begin
				if (is_add) begin
					fill_q <= blk_done ? 4'd0 : cnt;
					len_q  <= len_next;
					open_q <= 1'b1;
				end
				if (job_push) begin
					newkey_q <= 1'b0;
				end
			end
		end
	end

	// The seed is taken when the first byte opens a key.
	always_ff @(posedge clk) begin
		if (accept && is_add) begin
			if (!open_q) begin
				seed_q <= init_value;
			end
			for (int i = 0; i < HELD_BYTES; i++) begin
				if (fill_q == 4'(i)) begin
					bytes_q[i] <= data_byte;
				end
			end
		end
	end

endmodule

### hw/rtl/bmkh_fifo.sv
// ----------------------------------------------------------------------------
// bmkh_fifo
// Short job queue between the byte front end and the mixing back end.
// ----------------------------------------------------------------------------
module bmkh_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bmkh_pkg::job_t      din,
	input  logic                pop,
	output bmkh_pkg::job_t      dout,
	output bmkh_pkg::q_status_t status
);
	import bmkh_pkg::*;

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

### hw/rtl/bmkh_back.sv
// ----------------------------------------------------------------------------
// bmkh_back
// Holds the three hash words and runs the mix one line per cycle on a
// rotating register triple; adds the key length and presents the hash.
// ----------------------------------------------------------------------------
module bmkh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bmkh_pkg::job_t      q_job,
	input  bmkh_pkg::q_status_t q_status,
	output logic                q_pop,
	output logic                res_valid,
	output logic [31:0]         res_hash,
	input  logic                res_ready
);
	import bmkh_pkg::*;

	back_state_t state_q;
	back_state_t state_next;
	logic [3:0]  step_q;
	logic        final_q;
	logic        fin_pend_q;
	logic [31:0] r0_q;
	logic [31:0] r1_q;
	logic [31:0] r2_q;
	logic [31:0] len_q;
	logic [31:0] base_a;
	logic [31:0] base_b;
	logic [31:0] base_c;

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_next = q_job.do_block ? BK_MIX : BK_TAIL;
				end
			end
			BK_MIX: begin
				if (step_q == MIX_LAST) begin
					if (final_q) begin
						state_next = BK_EMIT;
					end else if (fin_pend_q) begin
						state_next = BK_TAIL;
					end else begin
						state_next = BK_IDLE;
					end
				end
			end
			BK_TAIL: begin
				state_next = BK_MIX;
			end
			BK_EMIT: begin
				if (res_ready) begin
					state_next = BK_IDLE;
				end
			end
			default: begin
				state_next = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = (state_q == BK_IDLE) && !q_status.empty;
		res_valid = (state_q == BK_EMIT);
		res_hash  = r2_q;
	end

	assign base_a = q_job.new_key ? GOLDEN_RATIO : r0_q;
	assign base_b = q_job.new_key ? GOLDEN_RATIO : r1_q;
	assign base_c = q_job.new_key ? q_job.seed : r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			step_q     <= '0;
			final_q    <= 1'b0;
			fin_pend_q <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						fin_pend_q <= q_job.do_finish;
						final_q    <= 1'b0;
						step_q     <= '0;
					end
				end
				BK_MIX: begin
					step_q <= (step_q == MIX_LAST) ? 4'd0 : step_q + 4'd1;
				end
				BK_TAIL: begin
					final_q    <= 1'b1;
					fin_pend_q <= 1'b0;
					step_q     <= '0;
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// After nine rotations the triple is back in a, b, c order.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					r0_q  <= base_a + q_job.add_a;
					r1_q  <= base_b + q_job.add_b;
					r2_q  <= base_c + q_job.add_c;
					len_q <= q_job.key_len;
				end
			end
			BK_MIX: begin
				r0_q <= r1_q;
				r1_q <= r2_q;
				r2_q <= mix_line(step_q, r0_q, r1_q, r2_q);
			end
			BK_TAIL: begin
				r2_q <= r2_q + len_q;
			end
			default: begin
				r2_q <= r2_q;
			end
		endcase
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the lookup2 key hash block. Key bytes are streamed in with random
// gaps, and an in-bench copy of the hash predicts every finished key. Hashes
// are compared in order while the output side stalls at random. The seed
// register is rewritten between phases, including its extreme values.
// ----------------------------------------------------------------------------
module testbench;
	import bmkh_pkg::*;

	localparam logic [1:0]        ACT_NONE    = 2'd3;
	localparam int                BLOCK_BYTES = 12;
	localparam logic [ADDR_W-1:0] SEED_ADDR   = {REG_INIT_IDX, 2'b00};
	localparam int                SETTLE      = 48;
	localparam int                CYCLE_LIMIT = 400000;
	localparam int                CALM_FROM   = 2000;
	localparam int                CALM_TO     = 3500;
	localparam int                PHASES      = 5;
	localparam int                PHASE_ITEMS = 400;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] dat;
		logic [7:0] reps;
		logic [1:0] hashes;
	} stim_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic [1:0]  s_axis_tuser  = ACT_ADD;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0] pwdata        = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] cycle_count = 32'd0;
	int          fail_count  = 0;
	logic        calm;

	// Predictor state for the key in progress.
	logic [31:0] seed_reg;
	logic [31:0] mix_a;
	logic [31:0] mix_b;
	logic [31:0] mix_c;
	logic [7:0]  tail_bytes [BLOCK_BYTES];
	int          tail_fill;
	logic [31:0] key_len;
	bit          key_open;
	logic [31:0] pending_hashes [$];

	stim_row_t   directed_rows [0:8];
	logic [31:0] seed_plan [PHASES];

	block_mix_key_hash u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not complete", $realtime);
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: check each transfer against the oldest pending hash.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_hashes.size() == 0) begin
					$display("%0t: unexpected hash, expected none, got %08h",
					         $realtime, m_axis_tdata);
					fail_count++;
				end else begin
					if (m_axis_tdata !== pending_hashes[0]) begin
						$display("%0t: hash mismatch, expected %08h, got %08h",
						         $realtime, pending_hashes[0], m_axis_tdata);
						fail_count++;
					end
					void'(pending_hashes.pop_front());
				end
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
		end
	end

	task automatic restart_key();
		mix_a     = GOLDEN_RATIO;
		mix_b     = GOLDEN_RATIO;
		mix_c     = seed_reg;
		tail_fill = 0;
		key_len   = 32'd0;
		key_open  = 1'b0;
	endtask

	task automatic churn_words();
		mix_a = mix_a - mix_b - mix_c; mix_a = mix_a ^ (mix_c >> 13);
		mix_b = mix_b - mix_c - mix_a; mix_b = mix_b ^ (mix_a << 8);
		mix_c = mix_c - mix_a - mix_b; mix_c = mix_c ^ (mix_b >> 13);
		mix_a = mix_a - mix_b - mix_c; mix_a = mix_a ^ (mix_c >> 12);
		mix_b = mix_b - mix_c - mix_a; mix_b = mix_b ^ (mix_a << 16);
		mix_c = mix_c - mix_a - mix_b; mix_c = mix_c ^ (mix_b >> 5);
		mix_a = mix_a - mix_b - mix_c; mix_a = mix_a ^ (mix_c >> 3);
		mix_b = mix_b - mix_c - mix_a; mix_b = mix_b ^ (mix_a << 10);
		mix_c = mix_c - mix_a - mix_b; mix_c = mix_c ^ (mix_b >> 15);
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		key_open = 1'b1;
		tail_bytes[tail_fill] = b;
		tail_fill++;
		key_len++;
		if (tail_fill == BLOCK_BYTES) begin
			mix_a += {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]};
			mix_b += {tail_bytes[7], tail_bytes[6], tail_bytes[5], tail_bytes[4]};
			mix_c += {tail_bytes[11], tail_bytes[10], tail_bytes[9], tail_bytes[8]};
			churn_words();
			tail_fill = 0;
		end
	endtask

	// The tail bytes 8..10 land one byte up in word c; its low byte
	// carries the length.
	task automatic close_key();
		logic [31:0] v;
		mix_c += key_len;
		for (int i = 0; i < tail_fill; i++) begin
			v = {24'h0, tail_bytes[i]};
			if (i < 4)
				mix_a += v << (8 * i);
			else if (i < 8)
				mix_b += v << (8 * (i - 4));
			else
				mix_c += v << (8 * (i - 7));
		end
		churn_words();
		pending_hashes.push_back(mix_c);
		restart_key();
	endtask

	task automatic hash_step(input logic [1:0] act, input logic [7:0] dat,
	                         output int n_out);
		n_out = 0;
		case (act)
			ACT_ADD: begin
				absorb_byte(dat);
			end
			ACT_ADD_FIN: begin
				absorb_byte(dat);
				close_key();
				n_out = 1;
			end
			ACT_FIN: begin
				close_key();
				n_out = 1;
			end
			default: begin
			end
		endcase
	endtask

	// Valid stays high from one transfer to the next unless a gap is drawn.
	task automatic push_item(input logic [1:0] act, input logic [7:0] dat,
	                         output int n_out);
		while (!calm && $urandom_range(0, 99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= dat;
		do @(posedge clk); while (!s_axis_tready);
		hash_step(act, dat, n_out);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_seed(input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SEED_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seed_reg = v;
		if (!key_open)
			mix_c = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v) begin
			$display("%0t: seed readback mismatch, expected %08h, got %08h",
			         $realtime, v, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'h00;
		else if (r < 20)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Whole keys with random content; unused action codes are mixed in as
	// noise and do not count toward the item total.
	task automatic run_keys(input int n_items);
		int count;
		int key_bytes;
		int r;
		int n;
		count = 0;
		while (count < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				key_bytes = 0;
			else if (r < 75)
				key_bytes = $urandom_range(1, 14);
			else if (r < 95)
				key_bytes = $urandom_range(15, 40);
			else
				key_bytes = $urandom_range(41, 120);
			for (int i = 0; i < key_bytes; i++) begin
				if ($urandom_range(0, 99) < 4)
					push_item(ACT_NONE, 8'($urandom_range(0, 255)), n);
				if (i == key_bytes - 1 && $urandom_range(0, 1) == 1)
					push_item(ACT_ADD_FIN, pick_byte(), n);
				else
					push_item(ACT_ADD, pick_byte(), n);
				count++;
			end
			if (!key_open && key_bytes != 0)
				continue;
			push_item(ACT_FIN, 8'($urandom_range(0, 255)), n);
			count++;
		end
	endtask

	initial begin
		int n;
		int got;
		directed_rows = '{
			'{ACT_FIN,     8'h00, 8'd1,  2'd1},  // empty key
			'{ACT_NONE,    8'hFF, 8'd1,  2'd0},  // unused action is ignored
			'{ACT_ADD_FIN, 8'hFF, 8'd1,  2'd1},
			'{ACT_FIN,     8'hFF, 8'd1,  2'd1},  // empty key, byte ignored
			'{ACT_ADD,     8'hF0, 8'd10, 2'd0},
			'{ACT_NONE,    8'h00, 8'd1,  2'd0},
			'{ACT_ADD_FIN, 8'hFF, 8'd1,  2'd1},  // longest tail
			'{ACT_ADD,     8'h00, 8'd11, 2'd0},
			'{ACT_ADD_FIN, 8'h00, 8'd1,  2'd1}   // block fills on the finish
		};
		seed_plan = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom,
		              32'h8000_0000, $urandom};
		seed_reg = INIT_RESET;
		restart_key();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			got = 0;
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				push_item(directed_rows[r].act, directed_rows[r].dat + 8'(k), n);
				got += n;
			end
			if (got != directed_rows[r].hashes) begin
				$display("%0t: row %0d result count, expected %0d, got %0d",
				         $realtime, r, directed_rows[r].hashes, got);
				fail_count++;
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			program_seed(seed_plan[p]);
			run_keys(PHASE_ITEMS);
		end
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### block_mix_key_hash.f
+incdir+hw/rtl
hw/rtl/bmkh_pkg.sv
hw/rtl/bmkh_front.sv
hw/rtl/bmkh_fifo.sv
hw/rtl/bmkh_back.sv
hw/rtl/block_mix_key_hash.sv
tb/sv/testbench.sv
